// ===== src/r2y_pkg.sv =====
// ----------------------------------------------------------------------------
// r2y_pkg
// Shared types and constants for the RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
package r2y_pkg;

  localparam int unsigned PIX_W  = 8;   // one colour component
  localparam int unsigned PAIR_W = 9;   // sum of two components
  localparam int unsigned TOT_W  = 10;  // sum of four components
  localparam int unsigned ENTRY_W = 3 * PAIR_W;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;
  localparam logic [CFG_W-1:0] DIM_MIN          = 13'd2;
  localparam logic [CFG_W-1:0] HEIGHT_MAX       = 13'd4096;

  // luma weights, Q16
  localparam logic [15:0] Y_KR = 16'd13933;
  localparam logic [15:0] Y_KG = 16'd46871;
  localparam logic [15:0] Y_KB = 16'd4732;

  // chroma weights, Q16; the unit weight 32768 is a shift by 15
  localparam logic [14:0] CB_KR = 15'd7510;
  localparam logic [14:0] CB_KG = 15'd25258;
  localparam logic [14:0] CR_KG = 15'd29767;
  localparam logic [14:0] CR_KB = 15'd3001;
  localparam int unsigned UNIT_SHIFT = 15;

  localparam int unsigned CHR_W = 28;
  localparam logic [CHR_W-1:0] CHROMA_OFS = 28'd33554432;  // 128 << 18

  localparam logic [PIX_W-1:0] BYTE_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // one pixel on its way into the colour matrix
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [TOT_W-1:0] tot_r;
    logic [TOT_W-1:0] tot_g;
    logic [TOT_W-1:0] tot_b;
    logic             chroma;
    logic             last;
  } r2y_item_t;

endpackage

// ===== src/rgb_to_yuv420_bt709.sv =====
// ----------------------------------------------------------------------------
// rgb_to_yuv420_bt709
// RGB to full-range BT.709 YCbCr with 2x2 box-averaged chroma.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  s_axis   | in  | tdata: red, green, blue
//  m_axis   | out | tdata: luma, cb, cr; tuser: chroma_valid; tlast: frame_last
//  cfg      | in  | index 0 frame_width, index 1 frame_height, 13-bit data
//
//  One pixel per clock sustained while m_axis is not stalled; an input word
//  passes the line-store read stage, product stage and output register.
//  The line store is a single-port-per-direction RAM with registered read; an
//  entry is written on the even row and read on the odd row below it.
//  Reset clears counters and pair hold, presets frame size; line store is not
//  cleared. Stalls on m_axis ripple back through the stage valids to tready.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_bt709 #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // luma, cb, cr
  output logic        m_axis_tuser,   // chroma_valid
  output logic        m_axis_tlast    // frame_last
);

  localparam int unsigned COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned DIM_W      = 14;
  localparam int unsigned ROW_W      = 12;
  localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'(MAX_WIDTH);

  localparam int unsigned PW = r2y_pkg::PAIR_W;
  localparam int unsigned EW = r2y_pkg::ENTRY_W;

  // configuration
  logic [12:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= r2y_pkg::FRAME_WIDTH_RST;
      frame_height_q <= r2y_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (r2y_pkg::cfg_idx_e'(cfg_idx_i))
        r2y_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        r2y_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] width_eff;
  logic [12:0]      height_eff;

  always_comb begin
    if (frame_width_q < r2y_pkg::DIM_MIN) width_eff = DIM_W'(r2y_pkg::DIM_MIN);
    else if (DIM_W'(frame_width_q) > WIDTH_MAX) width_eff = WIDTH_MAX;
    else width_eff = DIM_W'(frame_width_q);
    if (frame_height_q < r2y_pkg::DIM_MIN) height_eff = r2y_pkg::DIM_MIN;
    else if (frame_height_q > r2y_pkg::HEIGHT_MAX) height_eff = r2y_pkg::HEIGHT_MAX;
    else height_eff = frame_height_q;
  end

  // input decode
  logic [7:0] in_r, in_g, in_b;
  assign in_r = s_axis_tdata[7:0];
  assign in_g = s_axis_tdata[15:8];
  assign in_b = s_axis_tdata[23:16];

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [23:0]      pair_hold_q;
  logic             row_end, frame_end, odd_col, odd_row;
  logic [ADDR_W-1:0] slot;
  logic [PW-1:0]    sum_r, sum_g, sum_b;

  logic s1_v_q, s1_rdy, accept, csc_ready;
  logic mem_we, mem_re;
  r2y_pkg::r2y_item_t s1_item_q, csc_item;

  assign s1_rdy        = !s1_v_q || csc_ready;
  assign s_axis_tready = s1_rdy;
  assign accept        = s_axis_tvalid && s1_rdy;

  always_comb begin
    row_end   = (DIM_W'(col_q) + DIM_W'(1)) >= width_eff;
    frame_end = (13'(row_q) + 13'd1) >= height_eff;
    odd_col   = col_q[0];
    odd_row   = row_q[0];
    slot      = ADDR_W'({1'b0, col_q} >> 1);
    sum_r     = PW'(pair_hold_q[23:16]) + PW'(in_r);
    sum_g     = PW'(pair_hold_q[15:8])  + PW'(in_g);
    sum_b     = PW'(pair_hold_q[7:0])   + PW'(in_b);
    mem_we    = accept && odd_col && !odd_row;
    mem_re    = accept && odd_col && odd_row;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + ROW_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      pair_hold_q <= '0;
      s1_v_q      <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= s_axis_tvalid;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        if (!odd_col) pair_hold_q <= {in_r, in_g, in_b};
      end
    end
  end

  // line store: even-row pair sums, one entry per column pair
  logic [EW-1:0] line_mem [LINE_DEPTH];
  logic [EW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[slot] <= {sum_r, sum_g, sum_b};
    if (mem_re) rd_q <= line_mem[slot];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.red    <= in_r;
      s1_item_q.green  <= in_g;
      s1_item_q.blue   <= in_b;
      s1_item_q.tot_r  <= r2y_pkg::TOT_W'(sum_r);
      s1_item_q.tot_g  <= r2y_pkg::TOT_W'(sum_g);
      s1_item_q.tot_b  <= r2y_pkg::TOT_W'(sum_b);
      s1_item_q.chroma <= odd_col && odd_row;
      s1_item_q.last   <= row_end && frame_end;
    end
  end

  // rd_q lines up with stage 1: it only moves on an accept, which also loads stage 1
  always_comb begin
    csc_item       = s1_item_q;
    csc_item.tot_r = s1_item_q.tot_r + r2y_pkg::TOT_W'(rd_q[3*PW-1:2*PW]);
    csc_item.tot_g = s1_item_q.tot_g + r2y_pkg::TOT_W'(rd_q[2*PW-1:PW]);
    csc_item.tot_b = s1_item_q.tot_b + r2y_pkg::TOT_W'(rd_q[PW-1:0]);
  end

  r2y_csc u_csc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (s1_v_q),
    .item_ready_o  (csc_ready),
    .item_i        (csc_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // line-store read data must hold while stage 1 waits
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !csc_ready |=> $stable(rd_q))
    else $error("line store read data moved under a stalled pixel");

  // the last pixel of a frame returns the counters to the origin
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && row_end && frame_end |=> col_q == '0 && row_q == '0)
    else $error("counters not cleared after end of frame");

  // a pixel without a completed block carries zero chroma
  a_no_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == '0)
    else $error("chroma set on a word without a completed block");

  // a write and a read of the line store never fall on the same pixel
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("line store written and read by one pixel");

endmodule

// ===== src/r2y_csc.sv =====
// ----------------------------------------------------------------------------
// r2y_csc
// Colour matrix: registered products, then sums, clamp and output register.
// ----------------------------------------------------------------------------
module r2y_csc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  r2y_pkg::r2y_item_t   item_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // luma, cb, cr
  output logic                 m_axis_tuser,   // chroma_valid
  output logic                 m_axis_tlast    // frame_last
);

  localparam int unsigned YP_W = 24;
  localparam int unsigned CP_W = 25;

  function automatic logic [7:0] clamp_q18(input logic [r2y_pkg::CHR_W-1:0] v);
    logic [7:0] res;
    if (v[r2y_pkg::CHR_W-1]) begin
      res = '0;
    end else if (|v[r2y_pkg::CHR_W-2:26]) begin
      res = r2y_pkg::BYTE_MAX;
    end else begin
      res = v[25:18];
    end
    return res;
  endfunction

  logic s2_v_q, out_v_q;
  logic s2_rdy, out_rdy;

  logic [YP_W-1:0] y_r_q, y_g_q, y_b_q;
  logic [CP_W-1:0] cb_r_q, cb_g_q, cr_g_q, cr_b_q, u_b_q, v_r_q;
  logic            s2_chroma_q, s2_last_q;

  logic [YP_W+1:0]            y_sum;
  logic [r2y_pkg::CHR_W-1:0]  u_sum, v_sum;
  logic [7:0]                 luma_d, cb_d, cr_d;

  logic [23:0] out_data_q;
  logic        out_user_q, out_last_q;

  assign out_rdy      = !out_v_q || m_axis_tready;
  assign s2_rdy       = !s2_v_q || out_rdy;
  assign item_ready_o = s2_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_rdy) s2_v_q <= item_valid_i;
      if (out_rdy) out_v_q <= s2_v_q;
    end
  end

  // product stage
  always_ff @(posedge clk_i) begin
    if (s2_rdy && item_valid_i) begin
      y_r_q  <= YP_W'(item_i.red)   * YP_W'(r2y_pkg::Y_KR);
      y_g_q  <= YP_W'(item_i.green) * YP_W'(r2y_pkg::Y_KG);
      y_b_q  <= YP_W'(item_i.blue)  * YP_W'(r2y_pkg::Y_KB);
      cb_r_q <= CP_W'(item_i.tot_r) * CP_W'(r2y_pkg::CB_KR);
      cb_g_q <= CP_W'(item_i.tot_g) * CP_W'(r2y_pkg::CB_KG);
      cr_g_q <= CP_W'(item_i.tot_g) * CP_W'(r2y_pkg::CR_KG);
      cr_b_q <= CP_W'(item_i.tot_b) * CP_W'(r2y_pkg::CR_KB);
      u_b_q  <= CP_W'(item_i.tot_b) << r2y_pkg::UNIT_SHIFT;
      v_r_q  <= CP_W'(item_i.tot_r) << r2y_pkg::UNIT_SHIFT;
      s2_chroma_q <= item_i.chroma;
      s2_last_q   <= item_i.last;
    end
  end

  always_comb begin
    y_sum = (YP_W+2)'(y_r_q) + (YP_W+2)'(y_g_q) + (YP_W+2)'(y_b_q);
    u_sum = r2y_pkg::CHROMA_OFS + r2y_pkg::CHR_W'(u_b_q)
            - r2y_pkg::CHR_W'(cb_r_q) - r2y_pkg::CHR_W'(cb_g_q);
    v_sum = r2y_pkg::CHROMA_OFS + r2y_pkg::CHR_W'(v_r_q)
            - r2y_pkg::CHR_W'(cr_g_q) - r2y_pkg::CHR_W'(cr_b_q);
    luma_d = (|y_sum[YP_W+1:YP_W]) ? r2y_pkg::BYTE_MAX : y_sum[YP_W-1:16];
    // no block completed: chroma reads as zero
    cb_d = s2_chroma_q ? clamp_q18(u_sum) : '0;
    cr_d = s2_chroma_q ? clamp_q18(v_sum) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && s2_v_q) begin
      out_data_q <= {cr_d, cb_d, luma_d};
      out_user_q <= s2_chroma_q;
      out_last_q <= s2_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule
